// File: hw/rtl/paired_path_transition_weight_core_macros.svh
// Assertion macros for the transition weight RTL.
`ifndef PAIRED_PATH_TRANSITION_WEIGHT_CORE_MACROS_SVH
`define PAIRED_PATH_TRANSITION_WEIGHT_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PPT_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ppt: invariant violated");

// Same-cycle implication.
`define PPT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt: implication violated");

`endif

// File: hw/rtl/ppt_pkg.sv
// Shared constants and types for the paired path transition weight core.
`timescale 1ns / 1ps

package ppt_pkg;

    // Path count and mask geometry
    localparam int PATH_COUNT = 64;
    localparam int MASK_W     = 64;
    localparam int POP_LVLS   = $clog2(MASK_W);
    localparam logic [MASK_W-1:0] PATH_MASK = {MASK_W{1'b1}} >> (MASK_W - PATH_COUNT);

    // Arithmetic widths
    localparam int CNT_W    = $clog2(PATH_COUNT + 1);
    localparam int SW_MAX   = PATH_COUNT * PATH_COUNT;
    localparam int SW_W     = $clog2(SW_MAX + 1);
    localparam int OS_W     = SW_W + CNT_W + 1;
    localparam int BB_W     = 2 * SW_W;
    localparam int PROB_W   = 32;
    localparam int FRAC_W   = 31;
    localparam int WEIGHT_W = 56;
    localparam int SUM_W    = BB_W + PROB_W + 2;

    localparam logic [PROB_W-1:0]   ONE_Q31    = 32'h8000_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOTH_STAY   = 2'd0,
        CFG_ONE_SWITCH  = 2'd1,
        CFG_BOTH_SWITCH = 2'd2
    } t_cfg_idx;

endpackage

// File: hw/rtl/ppt_popcount.sv
// Population count of one path mask as a balanced adder tree.
`timescale 1ns / 1ps

module ppt_popcount (
    input  logic [ppt_pkg::MASK_W-1:0] i_bits,
    output logic [ppt_pkg::CNT_W-1:0]  o_count
);

    logic [ppt_pkg::CNT_W-1:0] acc [ppt_pkg::MASK_W];

    // Pairwise reduction, one tree level per outer iteration
    always_comb begin
        for (int i = 0; i < ppt_pkg::MASK_W; i++) begin
            acc[i] = ppt_pkg::CNT_W'(i_bits[i]);
        end
        for (int l = 0; l < ppt_pkg::POP_LVLS; l++) begin
            for (int i = 0; i < (ppt_pkg::MASK_W >> (l + 1)); i++) begin
                acc[i] = acc[2*i] + acc[2*i+1];
            end
        end
        o_count = acc[0];
    end

endmodule

// File: hw/rtl/paired_path_transition_weight_core.sv
// Top level: five-stage pipeline computing pair HMM transition / start weights.
// An accepted beat passes the valid registers r_v1 to r_v5; r_v5 drives o_valid.
// Throughput: one beat per cycle while busy is low, no stalls.
// The path set by the 26x32 probability multiplier in stage four sets the clock.
// Reset (synchronous, active low) clears the pipeline valid bits, loads all
// three probabilities with 1.0, and holds busy high until the cycle after release.
`timescale 1ns / 1ps

`include "paired_path_transition_weight_core_macros.svh"

module paired_path_transition_weight_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_action,
    input  logic [ppt_pkg::MASK_W-1:0]      i_mask_first_from,
    input  logic [ppt_pkg::MASK_W-1:0]      i_mask_second_from,
    input  logic [ppt_pkg::MASK_W-1:0]      i_mask_first_to,
    input  logic [ppt_pkg::MASK_W-1:0]      i_mask_second_to,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppt_pkg::PROB_W-1:0]      i_cfg_data,
    // result
    output logic                            o_valid,
    output logic [ppt_pkg::WEIGHT_W-1:0]    o_weight
);

    localparam int TA_W = ppt_pkg::SW_W + ppt_pkg::PROB_W;
    localparam int TB_W = ppt_pkg::OS_W + ppt_pkg::PROB_W;
    localparam int TC_W = ppt_pkg::BB_W + ppt_pkg::PROB_W;

    // Configuration registers
    logic [ppt_pkg::PROB_W-1:0] r_p_stay, r_p_one, r_p_sw;
    logic                       r_busy;
    logic                       accept;

    // Stage 1: bit counts
    logic                       r_v1, r_start1;
    logic [ppt_pkg::CNT_W-1:0]  n_nf1, n_nf2, n_nt1, n_nt2, n_st1, n_st2;
    logic [ppt_pkg::CNT_W-1:0]  r_nf1, r_nf2, r_nt1, r_nt2, r_st1, r_st2;

    // Stage 2: switch counts and start product
    logic                       r_v2, r_start2;
    logic [ppt_pkg::CNT_W-1:0]  r_st1_2, r_st2_2;
    logic [ppt_pkg::SW_W-1:0]   n_sw1, n_sw2, n_sp2;
    logic [ppt_pkg::SW_W-1:0]   r_sw1, r_sw2, r_sp2;

    // Stage 3: count products
    logic                       r_v3, r_start3;
    logic [ppt_pkg::SW_W-1:0]   n_ss3, r_ss3, r_sp3;
    logic [ppt_pkg::OS_W-1:0]   n_os3, r_os3;
    logic [ppt_pkg::BB_W-1:0]   n_bb3, r_bb3;

    // Stage 4: weighted terms
    logic                       r_v4, r_start4;
    logic [TA_W-1:0]            r_ta4;
    logic [TB_W-1:0]            r_tb4;
    logic [TC_W-1:0]            r_tc4;
    logic [ppt_pkg::SW_W-1:0]   r_sp4;

    // Stage 5: sum, saturate, output
    logic                          r_v5;
    logic [ppt_pkg::SUM_W-1:0]     n_sum;
    logic [ppt_pkg::WEIGHT_W-1:0]  n_weight, r_weight;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Busy only while in reset and the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Probability register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_stay <= ppt_pkg::ONE_Q31;
            r_p_one  <= ppt_pkg::ONE_Q31;
            r_p_sw   <= ppt_pkg::ONE_Q31;
        end else if (i_cfg_we) begin
            unique case (ppt_pkg::t_cfg_idx'(i_cfg_index))
                ppt_pkg::CFG_BOTH_STAY:   r_p_stay <= i_cfg_data;
                ppt_pkg::CFG_ONE_SWITCH:  r_p_one  <= i_cfg_data;
                ppt_pkg::CFG_BOTH_SWITCH: r_p_sw   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Popcounts of masks and overlaps
    ppt_popcount u_pc_f1 (.i_bits(i_mask_first_from  & ppt_pkg::PATH_MASK), .o_count(n_nf1));
    ppt_popcount u_pc_f2 (.i_bits(i_mask_second_from & ppt_pkg::PATH_MASK), .o_count(n_nf2));
    ppt_popcount u_pc_t1 (.i_bits(i_mask_first_to    & ppt_pkg::PATH_MASK), .o_count(n_nt1));
    ppt_popcount u_pc_t2 (.i_bits(i_mask_second_to   & ppt_pkg::PATH_MASK), .o_count(n_nt2));
    ppt_popcount u_pc_s1 (
        .i_bits (i_mask_first_from & i_mask_first_to & ppt_pkg::PATH_MASK),
        .o_count(n_st1)
    );
    ppt_popcount u_pc_s2 (
        .i_bits (i_mask_second_from & i_mask_second_to & ppt_pkg::PATH_MASK),
        .o_count(n_st2)
    );

    // Stage 2 math: switch = product of mask counts minus overlap
    always_comb begin
        n_sw1 = ppt_pkg::SW_W'(r_nf1) * ppt_pkg::SW_W'(r_nt1) - ppt_pkg::SW_W'(r_st1);
        n_sw2 = ppt_pkg::SW_W'(r_nf2) * ppt_pkg::SW_W'(r_nt2) - ppt_pkg::SW_W'(r_st2);
        n_sp2 = ppt_pkg::SW_W'(r_nf1) * ppt_pkg::SW_W'(r_nf2);
    end

    // Stage 3 math: pair products per switch class
    always_comb begin
        n_ss3 = ppt_pkg::SW_W'(r_st1_2) * ppt_pkg::SW_W'(r_st2_2);
        n_os3 = ppt_pkg::OS_W'(r_sw1) * ppt_pkg::OS_W'(r_st2_2)
              + ppt_pkg::OS_W'(r_sw2) * ppt_pkg::OS_W'(r_st1_2);
        n_bb3 = ppt_pkg::BB_W'(r_sw1) * ppt_pkg::BB_W'(r_sw2);
    end

    // Stage 5 math: sum of terms with saturation, or start weight
    always_comb begin
        n_sum = ppt_pkg::SUM_W'(r_ta4) + ppt_pkg::SUM_W'(r_tb4) + ppt_pkg::SUM_W'(r_tc4);
        if (r_start4) begin
            n_weight = ppt_pkg::WEIGHT_W'({r_sp4, {ppt_pkg::FRAC_W{1'b0}}});
        end else if (n_sum > ppt_pkg::SUM_W'(ppt_pkg::WEIGHT_MAX)) begin
            n_weight = ppt_pkg::WEIGHT_MAX;
        end else begin
            n_weight = n_sum[ppt_pkg::WEIGHT_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        r_start1 <= i_action;
        r_nf1    <= n_nf1;
        r_nf2    <= n_nf2;
        r_nt1    <= n_nt1;
        r_nt2    <= n_nt2;
        r_st1    <= n_st1;
        r_st2    <= n_st2;

        r_start2 <= r_start1;
        r_st1_2  <= r_st1;
        r_st2_2  <= r_st2;
        r_sw1    <= n_sw1;
        r_sw2    <= n_sw2;
        r_sp2    <= n_sp2;

        r_start3 <= r_start2;
        r_ss3    <= n_ss3;
        r_os3    <= n_os3;
        r_bb3    <= n_bb3;
        r_sp3    <= r_sp2;

        r_start4 <= r_start3;
        r_ta4    <= TA_W'(r_ss3) * TA_W'(r_p_stay);
        r_tb4    <= TB_W'(r_os3) * TB_W'(r_p_one);
        r_tc4    <= TC_W'(r_bb3) * TC_W'(r_p_sw);
        r_sp4    <= r_sp3;

        r_weight <= n_weight;
    end

    assign o_valid  = r_v5;
    assign o_weight = r_weight;

    // Every accepted beat yields exactly one result, and o_valid rises only for accepted beats
    `PPT_ASSERT_ALWAYS(a_one_result_per_beat, i_clk, i_rst_n, o_valid == $past(accept, 5))
    // Switch counts never wrap below zero
    `PPT_ASSERT_IMPLIES(a_switch_range, i_clk, i_rst_n, r_v2,
        (r_sw1 <= ppt_pkg::SW_W'(ppt_pkg::SW_MAX)) && (r_sw2 <= ppt_pkg::SW_W'(ppt_pkg::SW_MAX)))
    // Start weights are whole numbers
    `PPT_ASSERT_IMPLIES(a_start_integral, i_clk, i_rst_n, o_valid && $past(r_start4),
        o_weight[ppt_pkg::FRAC_W-1:0] == '0)

endmodule
